[rtl/bf3_pkg.sv]
// ---------------------------------------------------------------------------
// bf3_pkg - shared types and constants of the 3x3 box filter
// pixel and sum types, line store word, result set and the divide by nine
// ---------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int SUM_W      = 12;
    localparam int COORD_W    = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
    localparam int DIV9_W     = 13;
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIV9_W-1:0] DIV9_MUL = 13'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_THREE_CHANNEL = 2'd2
    } cfg_index_t;

    typedef logic [PIX_W-1:0] sample_t;
    // channel k in bits 8k..8k+7
    typedef sample_t [NUM_CH-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef sum_t [NUM_CH-1:0] pix_sum_t;
    // result order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
    typedef pix_sum_t [3:0] res_sums_t;

    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_pair_t;

    typedef struct packed {
        pixel_t px;
        logic   r_ge1;
        logic   r_ge2;
        logic   c_ge1;
        logic   c_ge2;
        logic   row_end;
        logic   last_row;
        logic   new_ok;
        logic   old_ok;
    } item_flags_t;

    typedef struct packed {
        logic [3:0]         mask;
        res_sums_t          sums;
        logic [COORD_W-1:0] row_prev;
        logic [COORD_W-1:0] row_cur;
        logic [COORD_W-1:0] col_prev;
        logic [COORD_W-1:0] col_cur;
        logic               frame_end;
    } result_set_t;

    function automatic sample_t div9(input sum_t s);
        logic [SUM_W+DIV9_W-1:0] prod;
        prod = (SUM_W + DIV9_W)'(s) * (SUM_W + DIV9_W)'(DIV9_MUL);
        return sample_t'(prod >> DIV9_SHIFT);
    endfunction

endpackage

`default_nettype wire

[rtl/bf3_line_store.sv]
// ---------------------------------------------------------------------------
// bf3_line_store - two line stores in one memory word
// one write and one registered read per cycle, write data bypassed on a clash
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire bf3_pkg::line_pair_t wr_data,
    output bf3_pkg::line_pair_t      rd_data
);
    import bf3_pkg::*;

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/bf3_window.sv]
// ---------------------------------------------------------------------------
// bf3_window - 3x3 window and neighbourhood sums
// edge gating, two stored columns and the four candidate sums of one pixel
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_window (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire bf3_pkg::item_flags_t flags,
    input  wire bf3_pkg::line_pair_t  rd,
    output bf3_pkg::res_sums_t        sums,
    output bf3_pkg::line_pair_t       wr
);
    import bf3_pkg::*;

    typedef pixel_t [2:0] column_t;

    // [0..2] column c-1 top to bottom, [3..5] column c-2
    pixel_t [5:0] win_reg;
    pixel_t [5:0] win_next;

    pixel_t  true_newer;
    pixel_t  true_older;
    column_t cur;
    column_t p1;
    column_t p2;

    function automatic pix_sum_t col_sum(input column_t col, input logic with_top);
        pix_sum_t s;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            s[ch] = SUM_W'(col[1][ch]) + SUM_W'(col[2][ch])
                  + (with_top ? SUM_W'(col[0][ch]) : SUM_W'(0));
        end
        return s;
    endfunction

    function automatic pix_sum_t add_sum(input pix_sum_t a, input pix_sum_t b);
        pix_sum_t s;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            s[ch] = a[ch] + b[ch];
        end
        return s;
    endfunction

    always_comb
    begin
        true_newer = flags.new_ok ? rd.newer : '0;
        true_older = flags.old_ok ? rd.older : '0;
        cur[0] = flags.r_ge2 ? true_older : '0;
        cur[1] = flags.r_ge1 ? true_newer : '0;
        cur[2] = flags.px;
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = flags.c_ge1 ? win_reg[i] : '0;
            p2[i] = flags.c_ge2 ? win_reg[3+i] : '0;
            win_next[i]   = cur[i];
            win_next[3+i] = p1[i];
        end
        wr.older = true_newer;
        wr.newer = flags.px;
    end

    always_comb
    begin
        sums[1] = add_sum(col_sum(p1, 1'b1), col_sum(cur, 1'b1));
        sums[0] = add_sum(sums[1], col_sum(p2, 1'b1));
        sums[3] = add_sum(col_sum(p1, 1'b0), col_sum(cur, 1'b0));
        sums[2] = add_sum(sums[3], col_sum(p2, 1'b0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (adv)
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bf3_result_seq.sv]
// ---------------------------------------------------------------------------
// bf3_result_seq - result set holder and output register
// sends the results of one pixel one per transfer, dividing by nine as each enters the output register
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_result_seq (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire bf3_pkg::result_set_t                set_in,
    input  wire logic                                three_channel,
    output logic                                     set_free,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // avg_ch0, avg_ch1, avg_ch2, out_row, out_col, zero fill
    output logic [bf3_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic                                     m_tlast,
    // run_last
    output logic                                     m_tuser
);
    import bf3_pkg::*;

    result_set_t        set_reg;
    logic [3:0]         mask_reg;
    logic [3:0]         mask_next;
    logic [3:0]         pick_oh;
    logic [1:0]         pick_idx;
    logic [3:0]         rest;
    logic               out_load;

    logic               out_valid_reg;
    sample_t [2:0]      avg_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               run_last_reg;
    logic               frame_last_reg;

    always_comb
    begin
        pick_idx = 2'd0;
        pick_oh  = 4'b0000;
        if (mask_reg[0])
        begin
            pick_idx = 2'd0;
            pick_oh  = 4'b0001;
        end
        else if (mask_reg[1])
        begin
            pick_idx = 2'd1;
            pick_oh  = 4'b0010;
        end
        else if (mask_reg[2])
        begin
            pick_idx = 2'd2;
            pick_oh  = 4'b0100;
        end
        else if (mask_reg[3])
        begin
            pick_idx = 2'd3;
            pick_oh  = 4'b1000;
        end
        out_load  = (mask_reg != 4'b0000) && (!out_valid_reg || m_tready);
        rest      = mask_reg & ~(out_load ? pick_oh : 4'b0000);
        set_free  = (rest == 4'b0000);
        mask_next = load ? set_in.mask : rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg <= set_in;
        end
        if (out_load)
        begin
            avg_reg[0]     <= div9(set_reg.sums[pick_idx][0]);
            avg_reg[1]     <= three_channel ? div9(set_reg.sums[pick_idx][1]) : '0;
            avg_reg[2]     <= three_channel ? div9(set_reg.sums[pick_idx][2]) : '0;
            row_reg        <= pick_idx[1] ? set_reg.row_cur : set_reg.row_prev;
            col_reg        <= pick_idx[0] ? set_reg.col_cur : set_reg.col_prev;
            run_last_reg   <= (rest == 4'b0000);
            frame_last_reg <= (rest == 4'b0000) && set_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, col_reg, row_reg, avg_reg[2], avg_reg[1], avg_reg[0]};
    assign m_tlast  = frame_last_reg;
    assign m_tuser  = run_last_reg;

endmodule

`default_nettype wire

[rtl/box_filter_3x3_zero_pad_core.sv]
// ---------------------------------------------------------------------------
// box_filter_3x3_zero_pad_core - zero padded 3x3 box filter over a pixel stream
// truncated mean of nine samples per output pixel, one or three channels
// ---------------------------------------------------------------------------
// path: input transfer, pixel stage, result set holder, output register, then m_tvalid
// throughput: one pixel per cycle while each pixel releases at most one result;
//   results leave one per cycle while m_tready holds, so a pixel releasing more (up
//   to 2 at a row end or on the last row, 4 at the frame end) stalls the input meanwhile
// reset: counters and window cleared, registers at 512 x 512 three channel;
//   the line store memory is not cleared, two fill marks give never written
//   columns as zero, so there is no clearing pass
`default_nettype none

module box_filter_3x3_zero_pad_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bf3_pkg::CFG_W-1:0]       cfg_wdata,
    // pixel input: pix_ch0, pix_ch1, pix_ch2
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bf3_pkg::IN_DATA_W-1:0]   s_tdata,
    // result output: avg_ch0, avg_ch1, avg_ch2, out_row, out_col, zero fill
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bf3_pkg::OUT_DATA_W-1:0]       m_tdata,
    // frame_last
    output logic                                 m_tlast,
    // run_last
    output logic                                 m_tuser
);
    import bf3_pkg::*;

    // counter widths; compares run wide enough for both the register and the limit
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW1 = CW + 1;
    localparam int LWC = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int LWR = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic             three_channel_reg;

    // raster position of the next pixel
    logic [CW-1:0]    col_count_reg;
    logic [CW-1:0]    col_count_next;
    logic [RW-1:0]    row_count_reg;
    logic [RW-1:0]    row_count_next;

    // fill marks: columns 0..fill-1 written at least once / at least twice
    logic [CW1-1:0]   fill_new_reg;
    logic [CW1-1:0]   fill_new_next;
    logic [CW1-1:0]   fill_old_reg;
    logic [CW1-1:0]   fill_old_next;

    // effective frame size and position decode
    logic [LWC-1:0]   w_ext;
    logic [LWC-1:0]   w_eff;
    logic [LWR-1:0]   h_ext;
    logic [LWR-1:0]   h_eff;
    logic [LWC-1:0]   col_ext;
    logic [LWR-1:0]   row_ext;
    item_flags_t      flags_in;
    logic             accept;

    // pixel stage: pixel and line store read data meet here
    logic               s1_valid_reg;
    item_flags_t        s1_flags_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [COORD_W-1:0] s1_row_prev_reg;
    logic [COORD_W-1:0] s1_row_cur_reg;
    logic [COORD_W-1:0] s1_col_prev_reg;
    logic [COORD_W-1:0] s1_col_cur_reg;
    logic               s1_adv;

    line_pair_t       rd_data;
    line_pair_t       wr_data;
    res_sums_t        sums;
    result_set_t      set_in;
    logic             set_free;

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= CFG_W'(512);
            image_height_reg  <= CFG_W'(512);
            three_channel_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata;
                REG_THREE_CHANNEL: three_channel_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // input side: size clamp, edge decode, position and fill marks
    // ---------------------------------------------------------------------
    always_comb
    begin
        // zero acts as one, anything past the maximum as the maximum
        w_ext = LWC'(image_width_reg);
        h_ext = LWR'(image_height_reg);
        if (w_ext == '0)
        begin
            w_eff = LWC'(1);
        end
        else if (w_ext > LWC'(MAX_WIDTH))
        begin
            w_eff = LWC'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        if (h_ext == '0)
        begin
            h_eff = LWR'(1);
        end
        else if (h_ext > LWR'(MAX_HEIGHT))
        begin
            h_eff = LWR'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end

        col_ext = LWC'(col_count_reg);
        row_ext = LWR'(row_count_reg);

        // a count at or past the last column or row (size changed mid frame)
        // still counts as the row end or last row
        flags_in.row_end  = (col_ext + LWC'(1)) >= w_eff;
        flags_in.last_row = (row_ext + LWR'(1)) >= h_eff;
        flags_in.c_ge1    = (col_ext >= LWC'(1));
        flags_in.c_ge2    = (col_ext >= LWC'(2));
        flags_in.r_ge1    = (row_ext >= LWR'(1));
        flags_in.r_ge2    = (row_ext >= LWR'(2));
        flags_in.new_ok   = CW1'(col_count_reg) < fill_new_reg;
        flags_in.old_ok   = CW1'(col_count_reg) < fill_old_reg;
        // single channel mode stores channels 1 and 2 as zero
        flags_in.px[0]    = s_tdata[7:0];
        flags_in.px[1]    = three_channel_reg ? s_tdata[15:8]  : '0;
        flags_in.px[2]    = three_channel_reg ? s_tdata[23:16] : '0;

        s_tready = !s1_valid_reg || s1_adv;
        accept   = s_tvalid && s_tready;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        fill_new_next  = fill_new_reg;
        fill_old_next  = fill_old_reg;
        if (accept)
        begin
            if (flags_in.row_end)
            begin
                col_count_next = '0;
                row_count_next = flags_in.last_row ? '0 : RW'(row_ext + LWR'(1));
            end
            else
            begin
                col_count_next = CW'(col_ext + LWC'(1));
            end
            // columns always run from zero upwards, so the written set is a prefix
            if (!flags_in.new_ok)
            begin
                fill_new_next = CW1'(col_count_reg) + CW1'(1);
            end
            else if (!flags_in.old_ok)
            begin
                fill_old_next = CW1'(col_count_reg) + CW1'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            fill_new_reg  <= '0;
            fill_old_reg  <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            fill_new_reg  <= fill_new_next;
            fill_old_reg  <= fill_old_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // pixel stage payload, coordinates masked to the output width
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg    <= flags_in;
            s1_col_reg      <= col_count_reg;
            s1_row_prev_reg <= COORD_W'(row_ext - LWR'(1));
            s1_row_cur_reg  <= COORD_W'(row_ext);
            s1_col_prev_reg <= COORD_W'(col_ext - LWC'(1));
            s1_col_cur_reg  <= COORD_W'(col_ext);
        end
    end

    // ---------------------------------------------------------------------
    // line stores: read at the input transfer, written as the pixel moves on
    // ---------------------------------------------------------------------
    bf3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------------
    // window and sums
    // ---------------------------------------------------------------------
    bf3_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (s1_adv),
        .flags (s1_flags_reg),
        .rd    (rd_data),
        .sums  (sums),
        .wr    (wr_data)
    );

    // which of the four neighbourhoods this pixel completes
    always_comb
    begin
        set_in.mask[0]   = s1_flags_reg.r_ge1 && s1_flags_reg.c_ge1;
        set_in.mask[1]   = s1_flags_reg.r_ge1 && s1_flags_reg.row_end;
        set_in.mask[2]   = s1_flags_reg.last_row && s1_flags_reg.c_ge1;
        set_in.mask[3]   = s1_flags_reg.last_row && s1_flags_reg.row_end;
        set_in.sums      = sums;
        set_in.row_prev  = s1_row_prev_reg;
        set_in.row_cur   = s1_row_cur_reg;
        set_in.col_prev  = s1_col_prev_reg;
        set_in.col_cur   = s1_col_cur_reg;
        set_in.frame_end = s1_flags_reg.last_row && s1_flags_reg.row_end;
    end

    // the pixel moves on once the result set holder is free (or frees now)
    assign s1_adv = s1_valid_reg && set_free;

    // ---------------------------------------------------------------------
    // result sequencing and output register
    // ---------------------------------------------------------------------
    bf3_result_seq u_result_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_adv),
        .set_in        (set_in),
        .three_channel (three_channel_reg),
        .set_free      (set_free),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // a column is written twice only after it has been written once
    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        fill_old_reg <= fill_new_reg)
        else $error("line store fill marks out of order");

    // the frame ends on the last result of a pixel
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("frame end without run end");

    // an accepted pixel is held in the pixel stage on the next cycle
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted pixel lost");

    // the column count never leaves the line store
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW1'(col_count_reg) < CW1'(MAX_WIDTH))
        else $error("column count beyond line store depth");

endmodule

`default_nettype wire
